// ===== rtl/sorted_set_dedup_filter_assert.svh =====
// -----------------------------------------------------------------------------
// Sorted set dedup filter assertion macros
// Shared property shapes for the port checker; clk and arst_n come from the
// scope of the use.
// -----------------------------------------------------------------------------
`ifndef SORTED_SET_DEDUP_FILTER_ASSERT_SVH
`define SORTED_SET_DEDUP_FILTER_ASSERT_SVH

// Same-cycle implication.
`define SSDF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define SSDF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/ssdf_pkg.sv =====
// -----------------------------------------------------------------------------
// Sorted set dedup filter package
// Sizes and the word types that travel along the cell chain.
// -----------------------------------------------------------------------------
package ssdf_pkg;

	localparam int CAPACITY = 256;
	localparam int KEY_W    = 64;
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int SUM_W    = CNT_W + 1;

	// Search word: walks the chain one cell per cycle while the chain advances,
	// resolves at its slot, then rides to the tail carrying its result.
	typedef struct packed {
		logic             vld;
		logic             done;
		logic             full;
		logic             first_seen;
		logic             drop;
		logic [KEY_W-1:0] key;
	} probe_t;

	// Displaced entry moving up by one slot per cycle while the chain advances.
	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
	} carry_t;

endpackage

// ===== rtl/sorted_set_dedup_filter.sv =====
// -----------------------------------------------------------------------------
// Sorted set dedup filter
// Reports whether each 64-bit key is new and keeps the distinct keys sorted.
// -----------------------------------------------------------------------------
// The store is a row of CAPACITY cells (256), each holding one key and a valid
// bit, ascending from cell 0. An accepted key enters cell 0 as a search word
// and moves one cell per cycle; at the first cell that is empty or holds a
// larger key it is inserted and the old entries shift up one cell per cycle
// behind a displacement wave, and at an equal key it is marked duplicate.
// The word then rides to the end of the chain, so results appear in input
// order. Keys enter one per cycle while the output is not stalled and the
// stored count plus the keys in flight stays below CAPACITY, and one per
// cycle again once the store is full; in between, the input stalls until
// the words in flight drain. A stalled result freezes the whole chain.
// When the store is full a new key is reported with first_seen and
// store_full_drop set and is not stored. Reset empties the store at once.
// -----------------------------------------------------------------------------
module sorted_set_dedup_filter (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       key_valid,
	output logic                       key_stall,
	input  logic [ssdf_pkg::KEY_W-1:0] key,
	output logic                       result_valid,
	input  logic                       result_stall,
	output logic                       first_seen,
	output logic                       store_full_drop
);

	ssdf_pkg::probe_t                  probe_w [ssdf_pkg::CAPACITY];
	ssdf_pkg::carry_t                  carry_w [ssdf_pkg::CAPACITY-1];
	ssdf_pkg::probe_t                  head;
	ssdf_pkg::probe_t                  tail;
	logic                              adv;
	logic                              admit;
	logic                              accept;
	logic                              tail_take;
	logic                              tail_store;
	logic                              full;
	logic [ssdf_pkg::CNT_W-1:0]        count_q;
	logic [ssdf_pkg::CNT_W-1:0]        pending_q;
	logic [ssdf_pkg::SUM_W-1:0]        load;
	logic                              out_vld_q;
	logic                              first_seen_q;
	logic                              drop_q;

	// Move the chain unless a result word sits stalled at the output.
	assign adv = !out_vld_q || !result_stall;

	// Admit a key only if every word in flight could still be stored; once
	// full, nothing more can change the store, so admit freely.
	assign full  = (count_q == ssdf_pkg::CNT_W'(ssdf_pkg::CAPACITY));
	assign load  = {1'b0, count_q} + {1'b0, pending_q};
	assign admit = full || (load < ssdf_pkg::SUM_W'(ssdf_pkg::CAPACITY));

	assign key_stall = !(adv && admit);
	assign accept    = key_valid && !key_stall;

	always_comb begin
		head            = '0;
		head.vld        = accept;
		head.full       = full;
		head.key        = key;
	end

	genvar gi;
	generate
		for (gi = 0; gi < ssdf_pkg::CAPACITY; gi++) begin : g_cell
			if (gi == 0) begin : g_first
				ssdf_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.adv       (adv),
					.probe_in  (head),
					.carry_in  ('0),
					.probe_out (probe_w[gi]),
					.carry_out (carry_w[gi])
				);
			end else if (gi == ssdf_pkg::CAPACITY - 1) begin : g_last
				// The top cell never displaces: admission keeps a free slot.
				ssdf_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.adv       (adv),
					.probe_in  (probe_w[gi-1]),
					.carry_in  (carry_w[gi-1]),
					.probe_out (probe_w[gi]),
					.carry_out ()
				);
			end else begin : g_mid
				ssdf_cell u_cell (
					.clk       (clk),
					.arst_n    (arst_n),
					.adv       (adv),
					.probe_in  (probe_w[gi-1]),
					.carry_in  (carry_w[gi-1]),
					.probe_out (probe_w[gi]),
					.carry_out (carry_w[gi])
				);
			end
		end
	endgenerate

	assign tail = probe_w[ssdf_pkg::CAPACITY-1];

	// A word that leaves unresolved found no slot: the store was full.
	assign tail_take  = tail.vld && adv;
	assign tail_store = tail_take && tail.done && tail.first_seen && !tail.drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q   <= '0;
			pending_q <= '0;
			out_vld_q <= 1'b0;
		end else begin
			if (tail_store) begin
				count_q <= count_q + ssdf_pkg::CNT_W'(1);
			end
			if (accept && !tail_take) begin
				pending_q <= pending_q + ssdf_pkg::CNT_W'(1);
			end else if (!accept && tail_take) begin
				pending_q <= pending_q - ssdf_pkg::CNT_W'(1);
			end
			if (adv) begin
				out_vld_q <= tail.vld;
			end
		end
	end

	// Hold the result payload while the output is stalled.
	always_ff @(posedge clk) begin
		if (adv) begin
			first_seen_q <= tail.done ? tail.first_seen : 1'b1;
			drop_q       <= tail.done ? tail.drop : 1'b1;
		end
	end

	assign result_valid    = out_vld_q;
	assign first_seen      = first_seen_q;
	assign store_full_drop = drop_q;

endmodule

// ===== rtl/ssdf_cell.sv =====
// -----------------------------------------------------------------------------
// Sorted set dedup filter cell
// Holds one slot of the sorted store; compares, inserts and shifts entries.
// -----------------------------------------------------------------------------
module ssdf_cell (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         adv,
	input  ssdf_pkg::probe_t             probe_in,
	input  ssdf_pkg::carry_t             carry_in,
	output ssdf_pkg::probe_t             probe_out,
	output ssdf_pkg::carry_t             carry_out
);

	logic [ssdf_pkg::KEY_W-1:0] key_q;
	logic [ssdf_pkg::KEY_W-1:0] key_nxt;
	logic                       vld_q;
	logic                       vld_nxt;
	logic                       hit;
	logic                       below;
	ssdf_pkg::probe_t           probe_q;
	ssdf_pkg::probe_t           probe_nxt;
	ssdf_pkg::carry_t           carry_q;
	ssdf_pkg::carry_t           carry_nxt;

	assign hit   = vld_q && (key_q == probe_in.key);
	assign below = vld_q && (key_q < probe_in.key);

	always_comb begin
		probe_nxt = probe_in;
		carry_nxt = '0;
		key_nxt   = key_q;
		vld_nxt   = vld_q;
		if (carry_in.vld) begin
			// take the displaced entry, push ours up
			key_nxt       = carry_in.key;
			vld_nxt       = 1'b1;
			carry_nxt.vld = vld_q;
			carry_nxt.key = key_q;
		end else if (probe_in.vld && !probe_in.done) begin
			if (hit) begin
				probe_nxt.done       = 1'b1;
				probe_nxt.first_seen = 1'b0;
				probe_nxt.drop       = 1'b0;
			end else if (!below) begin
				probe_nxt.done       = 1'b1;
				probe_nxt.first_seen = 1'b1;
				probe_nxt.drop       = probe_in.full;
				if (!probe_in.full) begin
					key_nxt       = probe_in.key;
					vld_nxt       = 1'b1;
					carry_nxt.vld = vld_q;
					carry_nxt.key = key_q;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= 1'b0;
			probe_q <= '0;
			carry_q <= '0;
		end else if (adv) begin
			vld_q   <= vld_nxt;
			probe_q <= probe_nxt;
			carry_q <= carry_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			key_q <= key_nxt;
		end
	end

	assign probe_out = probe_q;
	assign carry_out = carry_q;

endmodule

// ===== rtl/ssdf_checker.sv =====
// -----------------------------------------------------------------------------
// Sorted set dedup filter port checker
// Watches the top-level ports over time; attached to the top level by bind.
// -----------------------------------------------------------------------------
`include "sorted_set_dedup_filter_assert.svh"

module ssdf_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       key_valid,
	input logic                       key_stall,
	input logic [ssdf_pkg::KEY_W-1:0] key,
	input logic                       result_valid,
	input logic                       result_stall,
	input logic                       first_seen,
	input logic                       store_full_drop
);

	// hold a stalled result word
	`SSDF_ASSERT_NEXT(a_result_hold, result_valid && result_stall,
		result_valid && $stable(first_seen) && $stable(store_full_drop),
		"stalled result word changed")

	// a dropped key is always a new key
	`SSDF_ASSERT_NOW(a_drop_is_new, result_valid && store_full_drop, first_seen,
		"drop reported for a duplicate key")

	// once full, the input stalls only behind a stalled result
	`SSDF_ASSERT_NEXT(a_full_no_stall,
		result_valid && store_full_drop && !result_stall,
		!key_stall || (result_valid && result_stall),
		"input stalled after store became full")

	// a new key is only ever taken with data present
	`SSDF_ASSERT_NOW(a_key_known, key_valid && !key_stall, !$isunknown(key),
		"accepted key word has unknown bits")

endmodule

bind sorted_set_dedup_filter ssdf_checker u_ssdf_checker (.*);

// ===== test/tb_sorted_set_dedup_filter.sv =====
`timescale 1ns / 100ps
// -----------------------------------------------------------------------------
// Sorted set dedup filter testbench
// Streams 64-bit keys through the filter and checks every verdict against a
// sorted-store predictor. The predictor is kept in a small scoreboard class.
// The stimulus opens with directed edge keys. A random stream follows that
// fills the store and then keeps running against the full store. The stream
// rotates through free flow, source gaps, sink stalls, both at once, and long
// sink hold-offs.
// -----------------------------------------------------------------------------
module tb_sorted_set_dedup_filter;
	import ssdf_pkg::*;

	// Random stream length, and the cycles to wait once nothing is pending.
	localparam int unsigned RANDOM_KEYS  = 1500;
	localparam int unsigned LATENCY      = CAPACITY + 1;
	localparam int unsigned DRAIN_CYCLES = 2 * LATENCY + 16;
	localparam int unsigned HOLD_CYCLES  = 800;

	// Flow profiles that the random stream rotates through.
	typedef enum int unsigned {
		FLOW_FREE,
		FLOW_SRC_GAPS,
		FLOW_SINK_STALLS,
		FLOW_BOTH,
		FLOW_BACKPRESSURE
	} flow_mode_e;

	// -------------------------------------------------------------------------
	// Scoreboard: sorted-store predictor plus the queue of expected verdicts
	// -------------------------------------------------------------------------
	class dedup_scoreboard;
		typedef struct packed {
			logic first_seen;
			logic drop;
		} verdict_t;

		logic [KEY_W-1:0] sorted_store [CAPACITY];
		int unsigned      stored;
		verdict_t         verdict_q [$];
		int unsigned      mismatches;
		int unsigned      checked;
		int unsigned      n_new;
		int unsigned      n_dup;
		int unsigned      n_drop;

		function new();
			foreach (sorted_store[i]) sorted_store[i] = '0;
			stored     = 0;
			mismatches = 0;
			checked    = 0;
			n_new      = 0;
			n_dup      = 0;
			n_drop     = 0;
		endfunction

		// First used slot holding a key >= k, or the count if there is none.
		function int unsigned slot_for(logic [KEY_W-1:0] k);
			int unsigned lo;
			int unsigned hi;
			int unsigned mid;
			lo = 0;
			hi = stored;
			while (lo < hi) begin
				mid = lo + (hi - lo) / 2;
				if (sorted_store[mid] < k) lo = mid + 1;
				else hi = mid;
			end
			return lo;
		endfunction

		// Apply one accepted key to the store and queue its verdict.
		function void note_key(logic [KEY_W-1:0] k);
			int unsigned pos;
			verdict_t    v;
			pos = slot_for(k);
			if (pos < stored && sorted_store[pos] == k) begin
				v.first_seen = 1'b0;
				v.drop       = 1'b0;
				n_dup++;
			end else if (stored >= CAPACITY) begin
				// Full: report new, leave the store untouched.
				v.first_seen = 1'b1;
				v.drop       = 1'b1;
				n_drop++;
			end else begin
				for (int unsigned i = stored; i > pos; i--)
					sorted_store[i] = sorted_store[i - 1];
				sorted_store[pos] = k;
				stored++;
				v.first_seen = 1'b1;
				v.drop       = 1'b0;
				n_new++;
			end
			verdict_q.push_back(v);
		endfunction

		function void flag(string what);
			mismatches++;
			if (mismatches <= 10) $display("%0t: mismatch: %s", $realtime, what);
		endfunction

		// Compare one accepted result with the oldest queued verdict.
		function void check_result(logic fs_got, logic drop_got);
			verdict_t want;
			checked++;
			if (verdict_q.size() == 0) begin
				flag($sformatf("result %0d (first_seen=%b store_full_drop=%b) with none pending",
					checked, fs_got, drop_got));
				return;
			end
			want = verdict_q.pop_front();
			if (fs_got !== want.first_seen || drop_got !== want.drop)
				flag($sformatf("result %0d: first_seen exp %b got %b, store_full_drop exp %b got %b",
					checked, want.first_seen, fs_got, want.drop, drop_got));
		endfunction

		function int unsigned pending();
			return verdict_q.size();
		endfunction

		function bit failed();
			return mismatches != 0 || verdict_q.size() != 0;
		endfunction
	endclass

	// -------------------------------------------------------------------------
	// Clock, reset and the block
	// -------------------------------------------------------------------------
	logic             clk          = 1'b0;
	logic             arst_n       = 1'b0;
	logic             key_valid    = 1'b0;
	logic             key_stall;
	logic [KEY_W-1:0] key          = '0;
	logic             result_valid;
	logic             result_stall = 1'b0;
	logic             first_seen;
	logic             store_full_drop;

	dedup_scoreboard  sb = new();

	// Source and sink behavior, set by the stimulus between blocks of words.
	int unsigned      src_idle_pct   = 0;
	int unsigned      sink_stall_pct = 0;
	bit               hold_req       = 1'b0;
	int unsigned      hold_left      = 0;
	int unsigned      hold_count     = 0;

	// Keys offered so far; repeats and neighbors are drawn from here.
	logic [KEY_W-1:0] key_pool [$];

	initial begin
		forever #5 clk = ~clk;
	end

	sorted_set_dedup_filter dut (
		.clk             (clk),
		.arst_n          (arst_n),
		.key_valid       (key_valid),
		.key_stall       (key_stall),
		.key             (key),
		.result_valid    (result_valid),
		.result_stall    (result_stall),
		.first_seen      (first_seen),
		.store_full_drop (store_full_drop)
	);

	// -------------------------------------------------------------------------
	// Monitor: sample both handshakes at the edge, note the input word first
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (key_valid && !key_stall) sb.note_key(key);
			if (result_valid && !result_stall) sb.check_result(first_seen, store_full_drop);
		end
	end

	// -------------------------------------------------------------------------
	// Sink: random stalls, or a long hold-off when the stimulus asks for one.
	// Count the hold-off here so the source keeps offering words throughout it.
	// -------------------------------------------------------------------------
	always @(posedge clk) begin
		if (hold_req) begin
			hold_left = HOLD_CYCLES;
			hold_req  = 1'b0;
		end
		if (hold_left != 0) begin
			hold_left--;
			result_stall <= 1'b1;
		end else begin
			result_stall <= ($urandom_range(0, 99) < sink_stall_pct);
		end
	end

	// -------------------------------------------------------------------------
	// Source tasks
	// -------------------------------------------------------------------------

	// Pick the idle rates for a profile; backpressure also requests a hold-off.
	task automatic set_flow(input flow_mode_e mode);
		case (mode)
			FLOW_FREE: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
			end
			FLOW_SRC_GAPS: begin
				src_idle_pct   = 75;
				sink_stall_pct = 0;
			end
			FLOW_SINK_STALLS: begin
				src_idle_pct   = 0;
				sink_stall_pct = 75;
			end
			FLOW_BOTH: begin
				src_idle_pct   = 21;
				sink_stall_pct = 21;
			end
			FLOW_BACKPRESSURE: begin
				src_idle_pct   = 0;
				sink_stall_pct = 0;
				hold_req       = 1'b1;
				hold_count++;
			end
		endcase
	endtask

	// Offer one word and wait for its handshake. Idle cycles come first and
	// carry junk on the key lines; once valid is up, hold the key until taken.
	task automatic send_key(input logic [KEY_W-1:0] k);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			key_valid <= 1'b0;
			key       <= {$urandom, $urandom};
			@(posedge clk);
		end
		key_valid <= 1'b1;
		key       <= k;
		@(posedge clk);
		while (key_stall) @(posedge clk);
	endtask

	// Random key: repeats of earlier keys, their neighbors, a crowded low
	// range, values at or just under the top, and full-width random values.
	function automatic logic [KEY_W-1:0] pick_key();
		int unsigned      roll;
		logic [KEY_W-1:0] k;
		roll = $urandom_range(0, 99);
		if (roll < 55 && key_pool.size() != 0) begin
			k = key_pool[$urandom_range(0, key_pool.size() - 1)];
			if (roll >= 45) k = $urandom_range(0, 1) ? k + 1'b1 : k - 1'b1;
		end else if (roll < 70) begin
			k = KEY_W'($urandom_range(0, 63));
		end else if (roll < 78) begin
			k = '1 - KEY_W'($urandom_range(0, 63));
		end else begin
			k = {$urandom, $urandom};
		end
		return k;
	endfunction

	// -------------------------------------------------------------------------
	// Stimulus
	// -------------------------------------------------------------------------
	initial begin : stimulus
		logic [KEY_W-1:0] directed_keys [$];
		int unsigned      sent;
		int unsigned      block;
		int unsigned      block_len;
		flow_mode_e       mode;
		logic [KEY_W-1:0] k;

		// Empty store first, then both ends, an MSB-only key against its lower
		// neighbor to catch a signed compare, middle insertions, and repeats.
		directed_keys = '{
			64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h0000_0000_0000_0000, 64'hFFFF_FFFF_FFFF_FFFF,
			64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF,
			64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555,
			64'h0000_0000_0000_0001, 64'hFFFF_FFFF_FFFF_FFFE,
			64'h8000_0000_0000_0001, 64'h8000_0000_0000_0000,
			64'h7FFF_FFFF_FFFF_FFFF, 64'h0000_0001_0000_0000,
			64'h0000_0000_FFFF_FFFF, 64'h0000_0000_0000_0001,
			64'hAAAA_AAAA_AAAA_AAAA
		};

		// Hold reset, then release it once.
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		set_flow(FLOW_FREE);
		foreach (directed_keys[i]) begin
			key_pool.push_back(directed_keys[i]);
			send_key(directed_keys[i]);
		end

		// Rotate the flow profile every block of words. The backpressure block
		// is long enough to outlast the chain, so the input has to stall.
		sent  = 0;
		block = 0;
		while (sent < RANDOM_KEYS) begin
			mode = flow_mode_e'(block % 5);
			set_flow(mode);
			block_len = (mode == FLOW_BACKPRESSURE) ? 300 : 60;
			for (int unsigned j = 0; j < block_len && sent < RANDOM_KEYS; j++) begin
				k = pick_key();
				key_pool.push_back(k);
				send_key(k);
				sent++;
			end
			block++;
		end

		// Drop valid, let the sink run freely and drain every pending verdict.
		key_valid <= 1'b0;
		set_flow(FLOW_FREE);
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d keys: %0d stored as new, %0d duplicates, %0d new but dropped when full.",
			directed_keys.size() + sent, sb.n_new, sb.n_dup, sb.n_drop);
		$display("Checked %0d results over free flow, source gaps, sink stalls, both, and %0d hold-offs.",
			sb.checked, hold_count);
		if (sb.failed()) begin
			$display("%0d mismatches, %0d verdicts left pending", sb.mismatches, sb.pending());
			$display("[sorted_set_dedup_filter] ERROR");
		end else begin
			$display("[sorted_set_dedup_filter] OK");
		end
		$finish;
	end

	// -------------------------------------------------------------------------
	// Watchdog: long enough for every key to wait out the full chain under 75%
	// sink stalls, with margin on top for the hold-offs and the drain.
	// -------------------------------------------------------------------------
	initial begin
		#(100_000_000);
		$display("Timed out with %0d verdicts pending", sb.pending());
		$display("[sorted_set_dedup_filter] ERROR");
		$finish;
	end

endmodule

// ===== sorted_set_dedup_filter.f =====
+incdir+rtl
rtl/ssdf_pkg.sv
rtl/ssdf_cell.sv
rtl/sorted_set_dedup_filter.sv
rtl/ssdf_checker.sv
test/tb_sorted_set_dedup_filter.sv
